// ===== sv/cri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cri_pkg
// Shared widths, constants, register indexes and helpers of the Conrady
// refractive index evaluator.
// ----------------------------------------------------------------------------
package cri_pkg;

    localparam int WL_W      = 24;   // wavelength, unsigned Q16.8 nm
    localparam int COEFF_W   = 32;   // coefficients and index, signed Q4.28
    localparam int CFG_IDX_W = 3;

    localparam int DIV_N  = 49;      // quotient bits of both divisions
    localparam int R_W    = 38;      // 1/L in Q.20
    localparam int SR_W   = 29;      // sqrt(1/L) in Q.20
    localparam int R2_W   = 56;      // (1/L)^2 never exceeds this
    localparam int TERM_W = 61;      // capped terms
    localparam int SA_W   = 51;      // n0 + term_a
    localparam int FRAC_Q = 20;

    localparam logic [17:0]       NM_PER_UM_Q8 = 18'd256000;
    localparam logic [R_W-1:0]    RECIP_NUM    = 38'd268435456000;
    localparam logic [TERM_W-1:0] TERM_CAP     = {1'b1, {(TERM_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_INDEX = 3'd0,
        CFG_COEFF_A    = 3'd1,
        CFG_COEFF_B    = 3'd2,
        CFG_MIN_WL     = 3'd3,
        CFG_MAX_WL     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             oor;
        logic             zero;
        logic [SA_W-1:0]  sa;
        logic [R_W-1:0]   r;
        logic [SR_W-1:0]  sr;
    } t_side;

    // floor(p / 2^20), capped at TERM_CAP
    function automatic logic [TERM_W-1:0] qsat(input logic [95:0] p);
        logic [TERM_W-1:0] t;
        t = p[FRAC_Q +: TERM_W];
        if (|p[95:FRAC_Q+TERM_W] || (t > TERM_CAP)) begin
            return TERM_CAP;
        end
        return t;
    endfunction

endpackage

// ===== sv/cri_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cri_div_cell
// One restoring division step for two lanes sharing a divisor.
// ----------------------------------------------------------------------------
module cri_div_cell #(
    parameter int N  = 49,
    parameter int D  = 24,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [D-1:0]  i_div,
    input  logic [D-1:0]  i_rem0,
    input  logic [N-1:0]  i_qn0,
    input  logic [D-1:0]  i_rem1,
    input  logic [N-1:0]  i_qn1,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [D-1:0]  o_div,
    output logic [D-1:0]  o_rem0,
    output logic [N-1:0]  o_qn0,
    output logic [D-1:0]  o_rem1,
    output logic [N-1:0]  o_qn1,
    output logic [SW-1:0] o_side
);
    logic         r_valid;
    logic [D-1:0] r_div, r_rem0, r_rem1, n_rem0, n_rem1;
    logic [N-1:0] r_qn0, r_qn1, n_qn0, n_qn1;
    logic [SW-1:0] r_side;
    logic [D:0]   t0, t1;

    always_comb begin
        t0 = {i_rem0, i_qn0[N-1]};
        t1 = {i_rem1, i_qn1[N-1]};
        if (t0 >= {1'b0, i_div}) begin
            n_rem0 = D'(t0 - {1'b0, i_div});
            n_qn0  = {i_qn0[N-2:0], 1'b1};
        end else begin
            n_rem0 = t0[D-1:0];
            n_qn0  = {i_qn0[N-2:0], 1'b0};
        end
        if (t1 >= {1'b0, i_div}) begin
            n_rem1 = D'(t1 - {1'b0, i_div});
            n_qn1  = {i_qn1[N-2:0], 1'b1};
        end else begin
            n_rem1 = t1[D-1:0];
            n_qn1  = {i_qn1[N-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= i_div;
        r_rem0 <= n_rem0;
        r_qn0  <= n_qn0;
        r_rem1 <= n_rem1;
        r_qn1  <= n_qn1;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_rem0  = r_rem0;
    assign o_qn0   = r_qn0;
    assign o_rem1  = r_rem1;
    assign o_qn1   = r_qn1;
    assign o_side  = r_side;
endmodule

// ===== sv/cri_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cri_sqrt_cell
// One digit-by-digit integer square root step (one root bit).
// ----------------------------------------------------------------------------
module cri_sqrt_cell #(
    parameter int RW = 29,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    input  logic [2*RW-1:0] i_v,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root,
    output logic [2*RW-1:0] o_v,
    output logic [SW-1:0]   o_side
);
    localparam int VW = 2 * RW;

    logic          r_valid;
    logic [RW+1:0] r_rem, n_rem;
    logic [RW-1:0] r_root, n_root;
    logic [VW-1:0] r_v;
    logic [SW-1:0] r_side;
    logic [RW+3:0] t, trial;

    always_comb begin
        t     = {i_rem, i_v[VW-1 -: 2]};
        trial = (RW+4)'({i_root, 2'b01});
        if (t >= trial) begin
            n_rem  = (RW+2)'(t - trial);
            n_root = {i_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = t[RW+1:0];
            n_root = {i_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_v    <= {i_v[VW-3:0], 2'b00};
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_v     = r_v;
    assign o_side  = r_side;
endmodule

// ===== sv/cri_mul_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cri_mul_cell
// One shift-and-add multiply step: add a << K when bit K of b is set.
// ----------------------------------------------------------------------------
module cri_mul_cell #(
    parameter int AW = 38,
    parameter int BW = 38,
    parameter int K  = 0,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    input  logic [AW+BW-1:0] i_acc,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [AW-1:0]    o_a,
    output logic [BW-1:0]    o_b,
    output logic [AW+BW-1:0] o_acc,
    output logic [SW-1:0]    o_side
);
    localparam int PW = AW + BW;

    logic          r_valid;
    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc, n_acc;
    logic [SW-1:0] r_side;

    always_comb begin
        n_acc = i_acc + (i_b[K] ? (PW'(i_a) << K) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_b    <= i_b;
        r_acc  <= n_acc;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_acc   = r_acc;
    assign o_side  = r_side;
endmodule

// ===== sv/cri_mul_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cri_mul_chain
// Row of BW multiply cells giving the full product.
// ----------------------------------------------------------------------------
module cri_mul_chain #(
    parameter int AW = 38,
    parameter int BW = 38,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [AW+BW-1:0] o_prod,
    output logic [SW-1:0]    o_side
);
    logic             v   [0:BW];
    logic [AW-1:0]    a   [0:BW];
    logic [BW-1:0]    b   [0:BW];
    logic [AW+BW-1:0] acc [0:BW];
    logic [SW-1:0]    s   [0:BW];

    assign v[0]   = i_valid;
    assign a[0]   = i_a;
    assign b[0]   = i_b;
    assign acc[0] = '0;
    assign s[0]   = i_side;

    for (genvar k = 0; k < BW; k++) begin : g_cell
        cri_mul_cell #(.AW(AW), .BW(BW), .K(k), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .i_a     (a[k]),
            .i_b     (b[k]),
            .i_acc   (acc[k]),
            .i_side  (s[k]),
            .o_valid (v[k+1]),
            .o_a     (a[k+1]),
            .o_b     (b[k+1]),
            .o_acc   (acc[k+1]),
            .o_side  (s[k+1])
        );
    end

    assign o_valid = v[BW];
    assign o_prod  = acc[BW];
    assign o_side  = s[BW];
endmodule

// ===== sv/conrady_refractive_index_top.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle; busy is low whenever reset is released.
// The pipeline is built from the cell rows: 49 divide cells, 29 square root
// cells and 137 multiply cells, plus entry, fold, rounding and output
// registers. Reset is synchronous, active low: it clears all valid bits and
// reloads the configuration defaults. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// conrady_refractive_index_top
// Pipelined Conrady dispersion evaluator, n = n0 + A/L + B/L^3.5.
// ----------------------------------------------------------------------------
module conrady_refractive_index_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cri_pkg::WL_W-1:0]      i_wavelength,
    input  logic                          i_cfg_we,
    input  logic [cri_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [cri_pkg::COEFF_W-1:0]   i_cfg_data,
    output logic                          o_done,
    output logic signed [cri_pkg::COEFF_W-1:0] o_index,
    output logic                          o_out_of_range,
    output logic                          o_overflow
);
    import cri_pkg::*;

    localparam int SW = $bits(t_side);

    // ---------------- configuration registers ----------------
    logic signed [COEFF_W-1:0] r_base_index, r_coeff_a, r_coeff_b;
    logic [WL_W-1:0]           r_min_wl, r_max_wl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_index <= 32'sh1800_0000;
            r_coeff_a    <= '0;
            r_coeff_b    <= '0;
            r_min_wl     <= '0;
            r_max_wl     <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_BASE_INDEX: r_base_index <= i_cfg_data;
                CFG_COEFF_A:    r_coeff_a    <= i_cfg_data;
                CFG_COEFF_B:    r_coeff_b    <= i_cfg_data;
                CFG_MIN_WL:     r_min_wl     <= i_cfg_data[WL_W-1:0];
                CFG_MAX_WL:     r_max_wl     <= i_cfg_data[WL_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls; hold off requests only during reset.
    assign busy = !i_rst_n;

    logic accept;
    assign accept = start && !busy;

    // ---------------- entry: window test and |A| * 256000 ----------------
    logic              r_e_valid, r_e_oor, r_e_zero;
    logic [WL_W-1:0]   r_e_w;
    logic [DIV_N-1:0]  r_e_numa;
    logic [COEFF_W-1:0] mag_a;

    assign mag_a = r_coeff_a[COEFF_W-1] ? COEFF_W'(-r_coeff_a) : COEFF_W'(r_coeff_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_w    <= i_wavelength;
        r_e_oor  <= (i_wavelength < r_min_wl) || (i_wavelength > r_max_wl);
        r_e_zero <= (i_wavelength == '0);
        r_e_numa <= DIV_N'(mag_a) * DIV_N'(NM_PER_UM_Q8);
    end

    // ---------------- divide row: |A|*256000/W and (256000<<20)/W ----------------
    logic             dv_v  [0:DIV_N];
    logic [WL_W-1:0]  dv_d  [0:DIV_N];
    logic [WL_W-1:0]  dv_r0 [0:DIV_N];
    logic [DIV_N-1:0] dv_q0 [0:DIV_N];
    logic [WL_W-1:0]  dv_r1 [0:DIV_N];
    logic [DIV_N-1:0] dv_q1 [0:DIV_N];
    t_side            dv_s  [0:DIV_N];
    t_side            e_side;

    always_comb begin
        e_side      = '0;
        e_side.oor  = r_e_oor;
        e_side.zero = r_e_zero;
    end

    assign dv_v[0]  = r_e_valid;
    assign dv_d[0]  = r_e_w;
    assign dv_r0[0] = '0;
    assign dv_q0[0] = r_e_numa;
    assign dv_r1[0] = '0;
    assign dv_q1[0] = DIV_N'(RECIP_NUM);
    assign dv_s[0]  = e_side;

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        cri_div_cell #(.N(DIV_N), .D(WL_W), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .i_div   (dv_d[k]),
            .i_rem0  (dv_r0[k]),
            .i_qn0   (dv_q0[k]),
            .i_rem1  (dv_r1[k]),
            .i_qn1   (dv_q1[k]),
            .i_side  (dv_s[k]),
            .o_valid (dv_v[k+1]),
            .o_div   (dv_d[k+1]),
            .o_rem0  (dv_r0[k+1]),
            .o_qn0   (dv_q0[k+1]),
            .o_rem1  (dv_r1[k+1]),
            .o_qn1   (dv_q1[k+1]),
            .o_side  (dv_s[k+1])
        );
    end

    // ---------------- fold term_a into n0, keep 1/L ----------------
    logic            r_p_valid;
    t_side           r_p_side, n_p_side;
    logic [SA_W-1:0] ta_ext;

    always_comb begin
        ta_ext        = {2'b00, dv_q0[DIV_N]};
        n_p_side      = dv_s[DIV_N];
        n_p_side.r    = dv_q1[DIV_N][R_W-1:0];
        n_p_side.sa   = {{(SA_W-COEFF_W){r_base_index[COEFF_W-1]}}, r_base_index}
                      + (r_coeff_a[COEFF_W-1] ? SA_W'(-ta_ext) : ta_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= dv_v[DIV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_side <= n_p_side;
    end

    // ---------------- square root row: sqrt(r << 20) ----------------
    logic             sq_v    [0:SR_W];
    logic [SR_W+1:0]  sq_rem  [0:SR_W];
    logic [SR_W-1:0]  sq_root [0:SR_W];
    logic [2*SR_W-1:0] sq_val [0:SR_W];
    t_side            sq_s    [0:SR_W];

    assign sq_v[0]    = r_p_valid;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_val[0]  = {r_p_side.r, {FRAC_Q{1'b0}}};
    assign sq_s[0]    = r_p_side;

    for (genvar k = 0; k < SR_W; k++) begin : g_sqrt
        cri_sqrt_cell #(.RW(SR_W), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_v     (sq_val[k]),
            .i_side  (sq_s[k]),
            .o_valid (sq_v[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_v     (sq_val[k+1]),
            .o_side  (sq_s[k+1])
        );
    end

    // ---------------- r2 = q(r, r) ----------------
    t_side                m1_in_side, m1_side;
    logic                 m1_valid;
    logic [2*R_W-1:0]     m1_prod;

    always_comb begin
        m1_in_side    = sq_s[SR_W];
        m1_in_side.sr = sq_root[SR_W];
    end

    cri_mul_chain #(.AW(R_W), .BW(R_W), .SW(SW)) u_mul_r2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v[SR_W]),
        .i_a     (m1_in_side.r),
        .i_b     (m1_in_side.r),
        .i_side  (m1_in_side),
        .o_valid (m1_valid),
        .o_prod  (m1_prod),
        .o_side  (m1_side)
    );

    logic              r_q1_valid;
    logic [R2_W-1:0]   r_q1_m;
    t_side             r_q1_side;
    logic [TERM_W-1:0] q1_full;

    assign q1_full = qsat(96'(m1_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_valid <= 1'b0;
        end else begin
            r_q1_valid <= m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1_m    <= q1_full[R2_W-1:0];
        r_q1_side <= m1_side;
    end

    // ---------------- r3 = q(r2, r) ----------------
    t_side                m2_side;
    logic                 m2_valid;
    logic [R2_W+R_W-1:0]  m2_prod;

    cri_mul_chain #(.AW(R2_W), .BW(R_W), .SW(SW)) u_mul_r3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_q1_valid),
        .i_a     (r_q1_m),
        .i_b     (r_q1_side.r),
        .i_side  (r_q1_side),
        .o_valid (m2_valid),
        .o_prod  (m2_prod),
        .o_side  (m2_side)
    );

    logic              r_q2_valid;
    logic [TERM_W-1:0] r_q2_m;
    t_side             r_q2_side, n_q2_side;

    always_comb begin
        n_q2_side   = m2_side;
        n_q2_side.r = '0;   // drop 1/L, no longer needed
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2_valid <= 1'b0;
        end else begin
            r_q2_valid <= m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q2_m    <= qsat(96'(m2_prod));
        r_q2_side <= n_q2_side;
    end

    // ---------------- p = q(r3, sr) ----------------
    t_side                 m3_side;
    logic                  m3_valid;
    logic [TERM_W+SR_W-1:0] m3_prod;

    cri_mul_chain #(.AW(TERM_W), .BW(SR_W), .SW(SW)) u_mul_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_q2_valid),
        .i_a     (r_q2_m),
        .i_b     (r_q2_side.sr),
        .i_side  (r_q2_side),
        .o_valid (m3_valid),
        .o_prod  (m3_prod),
        .o_side  (m3_side)
    );

    logic              r_q3_valid;
    logic [TERM_W-1:0] r_q3_m;
    t_side             r_q3_side, n_q3_side;

    always_comb begin
        n_q3_side    = m3_side;
        n_q3_side.sr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q3_valid <= 1'b0;
        end else begin
            r_q3_valid <= m3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q3_m    <= qsat(96'(m3_prod));
        r_q3_side <= n_q3_side;
    end

    // ---------------- term_b = q(|B|, p) ----------------
    logic [COEFF_W-1:0]       mag_b;
    t_side                    m4_side;
    logic                     m4_valid;
    logic [TERM_W+COEFF_W-1:0] m4_prod;

    assign mag_b = r_coeff_b[COEFF_W-1] ? COEFF_W'(-r_coeff_b) : COEFF_W'(r_coeff_b);

    cri_mul_chain #(.AW(TERM_W), .BW(COEFF_W), .SW(SW)) u_mul_tb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_q3_valid),
        .i_a     (r_q3_m),
        .i_b     (mag_b),
        .i_side  (r_q3_side),
        .o_valid (m4_valid),
        .o_prod  (m4_prod),
        .o_side  (m4_side)
    );

    logic              r_q4_valid;
    logic [TERM_W-1:0] r_q4_tb;
    t_side             r_q4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q4_valid <= 1'b0;
        end else begin
            r_q4_valid <= m4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q4_tb   <= qsat(96'(m4_prod));
        r_q4_side <= m4_side;
    end

    // ---------------- final sum, clamp and special cases ----------------
    logic [63:0]        sum, tb_ext;
    logic               clamp_hi, clamp_lo, dir_pos, dir_neg;
    logic [COEFF_W-1:0] n_index;
    logic               n_ovf;
    logic signed [COEFF_W-1:0] dir;

    always_comb begin
        tb_ext   = {3'b000, r_q4_tb};
        sum      = {{(64-SA_W){r_q4_side.sa[SA_W-1]}}, r_q4_side.sa}
                 + (r_coeff_b[COEFF_W-1] ? -tb_ext : tb_ext);
        clamp_hi = !sum[63] && (|sum[62:31]);
        clamp_lo = sum[63] && !(&sum[62:31]);
        dir      = (r_coeff_b != '0) ? r_coeff_b : r_coeff_a;
        dir_pos  = !dir[COEFF_W-1] && (dir != '0);
        dir_neg  = dir[COEFF_W-1];
        n_ovf    = 1'b0;
        if (r_q4_side.oor) begin
            n_index = '0;
        end else if (r_q4_side.zero) begin
            n_ovf = 1'b1;
            if (dir_pos) begin
                n_index = {1'b0, {(COEFF_W-1){1'b1}}};
            end else if (dir_neg) begin
                n_index = {1'b1, {(COEFF_W-1){1'b0}}};
            end else begin
                n_index = r_base_index;
            end
        end else begin
            n_ovf = clamp_hi || clamp_lo ||
                    ((r_coeff_b != '0) && (r_q4_tb == TERM_CAP));
            if (clamp_hi) begin
                n_index = {1'b0, {(COEFF_W-1){1'b1}}};
            end else if (clamp_lo) begin
                n_index = {1'b1, {(COEFF_W-1){1'b0}}};
            end else begin
                n_index = sum[COEFF_W-1:0];
            end
        end
    end

    logic               r_o_valid, r_o_oor, r_o_ovf;
    logic [COEFF_W-1:0] r_o_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_q4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_index <= n_index;
        r_o_oor   <= r_q4_side.oor;
        r_o_ovf   <= n_ovf;
    end

    assign o_done         = r_o_valid;
    assign o_index        = r_o_index;
    assign o_out_of_range = r_o_oor;
    assign o_overflow     = r_o_ovf;
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined Conrady dispersion evaluator. It
// sweeps wavelengths under several coefficient and window settings. These
// include the all-ones and sign-bit extremes, a zero wavelength, window edges
// and an empty window. Every result is checked against a fixed-point model
// of n0 + A/L + B/L^3.5 that is computed when each request is accepted.
// ----------------------------------------------------------------------------
module tb_top;
    import cri_pkg::*;

    localparam int                   PIPE_LAT = 222;
    localparam longint unsigned      CAP      = 64'd1 << 60;

    typedef struct {
        logic signed [COEFF_W-1:0] idx;
        logic                      oor;
        logic                      ovf;
    } t_idx_res;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [WL_W-1:0]           i_wavelength = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_addr = CFG_BASE_INDEX;
    logic [COEFF_W-1:0]        i_cfg_data = '0;
    logic                      o_done;
    logic signed [COEFF_W-1:0] o_index;
    logic                      o_out_of_range;
    logic                      o_overflow;

    conrady_refractive_index_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_wavelength   (i_wavelength),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_index        (o_index),
        .o_out_of_range (o_out_of_range),
        .o_overflow     (o_overflow)
    );

    // Local copy of the coefficient and window registers, reset values first.
    logic signed [COEFF_W-1:0] n0_r   = 32'sh1800_0000;
    logic signed [COEFF_W-1:0] a_r    = '0;
    logic signed [COEFF_W-1:0] b_r    = '0;
    logic [WL_W-1:0]           wmin_r = '0;
    logic [WL_W-1:0]           wmax_r = 24'hFF_FFFF;

    logic [WL_W-1:0] pending_wl[$];   // wavelengths waiting to be requested
    t_idx_res        expected_idx[$]; // predicted results, oldest first
    int              gap_cnt = 0;
    bit              bursty = 0;      // when set, the sender never idles
    int              n_fail = 0;
    int              n_req = 0;
    int              n_oor = 0;
    int              n_ovf = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------

    // floor(x * y / 2^20), capped at 2^60
    function automatic longint unsigned qmul(longint unsigned x, longint unsigned y);
        logic [127:0] pr;
        pr = ({64'd0, x} * {64'd0, y}) >> FRAC_Q;
        if (pr > CAP) begin
            return CAP;
        end
        return pr[63:0];
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_idx_res conrady_index(logic [WL_W-1:0] wl);
        t_idx_res        res;
        longint unsigned ta, r, sr, p, tb, maga, magb;
        longint          sum, n0l, al, bl;
        n0l = longint'(n0_r);
        al  = longint'(a_r);
        bl  = longint'(b_r);
        res.oor = 1'b0;
        res.ovf = 1'b0;
        // Window test comes before anything else.
        if (wl < wmin_r || wl > wmax_r) begin
            res.idx = '0;
            res.oor = 1'b1;
            return res;
        end
        // Zero wavelength: saturate toward the sign of the dominant term.
        if (wl == 0) begin
            res.ovf = 1'b1;
            if ((bl != 0 ? bl : al) > 0) begin
                res.idx = 32'sh7FFF_FFFF;
            end else if ((bl != 0 ? bl : al) < 0) begin
                res.idx = 32'sh8000_0000;
            end else begin
                res.idx = n0_r;
            end
            return res;
        end
        maga = al < 0 ? longint'(-al) : al;
        magb = bl < 0 ? longint'(-bl) : bl;
        ta   = maga * 64'd256000 / wl;
        r    = (64'd256000 << FRAC_Q) / wl;
        sr   = isqrt(r << FRAC_Q);
        p    = qmul(qmul(qmul(r, r), r), sr);
        tb   = qmul(magb, p);
        if (bl != 0 && tb >= CAP) begin
            res.ovf = 1'b1;
        end
        sum = n0l + (al < 0 ? -longint'(ta) : longint'(ta))
                  + (bl < 0 ? -longint'(tb) : longint'(tb));
        if (sum > 64'sd2147483647) begin
            res.idx = 32'sh7FFF_FFFF;
            res.ovf = 1'b1;
        end else if (sum < -64'sd2147483648) begin
            res.idx = 32'sh8000_0000;
            res.ovf = 1'b1;
        end else begin
            res.idx = sum[31:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: issue one request per accepted edge, with random idle gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start   <= 1'b0;
            gap_cnt <= 0;
        end else begin
            // Predict at the accepting edge, with the registers as they stand.
            if (start && !busy) begin
                expected_idx.push_back(conrady_index(i_wavelength));
                n_req++;
            end
            if (start && busy) begin
                // hold the request until the block takes it
            end else if (gap_cnt != 0) begin
                gap_cnt <= gap_cnt - 1;
                start   <= 1'b0;
            end else if (pending_wl.size() != 0) begin
                start        <= 1'b1;
                i_wavelength <= pending_wl.pop_front();
                gap_cnt      <= bursty ? 0 : $urandom_range(0, 16);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each strobed result with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        n_fail++;
    endtask

    always @(posedge i_clk) begin
        t_idx_res e;
        if (i_rst_n && o_done) begin
            if (expected_idx.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                e = expected_idx.pop_front();
                if (o_index !== e.idx)
                    report_mismatch($sformatf("index %h, want %h", o_index, e.idx));
                if (o_out_of_range !== e.oor)
                    report_mismatch($sformatf("out_of_range %b, want %b",
                                              o_out_of_range, e.oor));
                if (o_overflow !== e.ovf)
                    report_mismatch($sformatf("overflow %b, want %b", o_overflow, e.ovf));
                if (e.oor) n_oor++;
                if (e.ovf) n_ovf++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Write all five registers; only called while the pipeline is empty.
    task automatic write_regs(logic [31:0] n0, logic [31:0] a, logic [31:0] b,
                              logic [23:0] wmin, logic [23:0] wmax);
        t_cfg_idx        addrs[5];
        logic [31:0]     vals[5];
        addrs = '{CFG_BASE_INDEX, CFG_COEFF_A, CFG_COEFF_B, CFG_MIN_WL, CFG_MAX_WL};
        vals  = '{n0, a, b, {8'd0, wmin}, {8'd0, wmax}};
        for (int k = 0; k < 5; k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= addrs[k];
            i_cfg_data <= vals[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n0_r   = n0;
        a_r    = a;
        b_r    = b;
        wmin_r = wmin;
        wmax_r = wmax;
    endtask

    // Hold off until every request has come back, then let the pipe drain.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_wl.size() != 0 || start || expected_idx.size() != 0);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
            2:       return '0;
            3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh8000);
        endcase
    endfunction

    function automatic logic [23:0] rand_wl();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom());
            1:       return 24'($urandom_range(wmin_r, wmax_r >= wmin_r ? wmax_r : wmin_r));
            2:       return 24'($urandom_range(300 << 8, 2500 << 8));
            default: return 24'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [23:0] lo, hi;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: flat index of 1.5 everywhere, zero wavelength too.
        pending_wl = '{24'd0, 24'd1, 24'hFF_FFFF, 24'd256000};
        drain();

        // Typical glass, wide window: both terms live, zero wavelength saturates.
        write_regs(32'h1800_0000, 32'h0020_0000, 32'h0001_0000, 24'd0, 24'hFF_FFFF);
        pending_wl = '{24'd0, 24'd1, 24'hFF_FFFF, 24'd256000, 24'(400 << 8),
                       24'(2000 << 8), 24'h80_0000, 24'h7F_FFFF};
        drain();

        // Positive extremes: terms and sum saturate high.
        write_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0, 24'hFF_FFFF);
        pending_wl = '{24'd0, 24'd1, 24'd256, 24'hFF_FFFF};
        drain();

        // Negative extremes: saturate low.
        write_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'd0, 24'hFF_FFFF);
        pending_wl = '{24'd0, 24'd1, 24'hFF_FFFF};
        drain();

        // B zero: zero wavelength follows the sign of A.
        write_regs(32'h1000_0000, 32'hFFFF_FFFF, 32'h0, 24'd0, 24'hFF_FFFF);
        pending_wl = '{24'd0, 24'd1000};
        drain();

        // Visible window: below, both edges, inside, above.
        write_regs(32'h1800_0000, 32'h0010_0000, 32'h0000_8000, 24'(400 << 8),
                   24'(700 << 8));
        pending_wl = '{24'((400 << 8) - 1), 24'(400 << 8), 24'(550 << 8),
                       24'(700 << 8), 24'((700 << 8) + 1), 24'd0};
        drain();

        // Empty window: everything out of range.
        write_regs(32'h1800_0000, 32'h0, 32'h0, 24'hFF_FFFF, 24'd0);
        pending_wl = '{24'd0, 24'd12345, 24'hFF_FFFF};
        drain();

        // Random phases; the first few run back to back with no gaps.
        for (int ph = 0; ph < 10; ph++) begin
            lo = 24'($urandom());
            hi = 24'($urandom());
            case ($urandom_range(0, 3))
                0:       write_regs(rand_coeff(), rand_coeff(), rand_coeff(), 24'd0,
                                    24'hFF_FFFF);
                1:       write_regs(rand_coeff(), rand_coeff(), rand_coeff(), lo,
                                    hi);
                default: write_regs(rand_coeff(), rand_coeff(), rand_coeff(),
                                    lo < hi ? lo : hi, lo < hi ? hi : lo);
            endcase
            bursty = (ph < 3);
            for (int k = 0; k < 48; k++) pending_wl.push_back(rand_wl());
            drain();
        end

        $display("Checked %0d requests over 17 register settings", n_req);
        $display("  %0d out of window, %0d saturated or zero wavelength", n_oor, n_ovf);
        if (n_fail == 0) begin
            $display("** conrady_refractive_index_top: PASSED **");
        end else begin
            $display("** conrady_refractive_index_top: FAILED **");
        end
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_idx.size());
        $display("** conrady_refractive_index_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cri_pkg.sv
sv/cri_div_cell.sv
sv/cri_sqrt_cell.sv
sv/cri_mul_cell.sv
sv/cri_mul_chain.sv
sv/conrady_refractive_index_top.sv
tb/sv/tb_top.sv
